@@ sv/vsrd_pkg.sv @@
package vsrd_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH         = 8'd0,
    REG_FRAME_HEIGHT        = 8'd1,
    REG_ACTIVATION_FRACTION = 8'd2,
    REG_DEAD_ZONE           = 8'd3
  } cfg_reg_t;

  localparam logic [15:0] FRAME_RESET    = 16'd2048;
  localparam logic [15:0] FRACTION_RESET = 16'd15729;
  localparam logic [15:0] DEAD_ZONE_RESET = 16'd6554;
  localparam logic [15:0] MIN_FRACTION   = 16'd15729;
  localparam logic [16:0] UNIT_Q16       = 17'h10000;
  localparam logic [15:0] AXIS_MAX       = 16'd32767;
  localparam logic [15:0] FLICK_MS       = 16'd340;
  localparam logic signed [15:0] FLICK_AXIS = 16'sd19005;

  // Stage map of the pipeline, one step of each iterative unit per stage.
  localparam int ST_SQ      = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_INIT    = 3;
  localparam int ST_DIV0    = 4;
  localparam int DIV_STEPS  = 32;
  localparam int ST_MSQ0    = ST_DIV0 + DIV_STEPS;
  localparam int MSQ_STEPS  = 16;
  localparam int ST_MAG     = ST_MSQ0 + MSQ_STEPS;
  localparam int ST_RDIV0   = ST_MAG + 1;
  localparam int RDIV_STEPS = 17;
  localparam int ST_PROD    = ST_RDIV0 + RDIV_STEPS;
  localparam int ST_NEG     = ST_PROD + 1;
  localparam int ST_ASUM    = ST_NEG + 1;
  localparam int ST_ADIV0   = ST_ASUM + 1;
  localparam int ADIV_STEPS = 16;
  localparam int ST_OUT     = ST_ADIV0 + ADIV_STEPS;

endpackage

@@ sv/vsrd_in_if.sv @@
interface vsrd_in_if #(
  parameter int CW = vsrd_pkg::COORD_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] anchor_x;
  logic [CW-1:0] anchor_y;
  logic [CW-1:0] current_x;
  logic [CW-1:0] current_y;
  logic [15:0]   elapsed_ms;
  logic          touch_started;

  modport source (output valid, anchor_x, anchor_y, current_x, current_y, elapsed_ms,
                  touch_started, input ready);
  modport sink (input valid, anchor_x, anchor_y, current_x, current_y, elapsed_ms,
                touch_started, output ready);
endinterface

@@ sv/vsrd_out_if.sv @@
interface vsrd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic               stick_active;
  logic               forward_flick;

  modport source (output valid, stick_x, stick_y, stick_active, forward_flick,
                  input ready);
  modport sink (input valid, stick_x, stick_y, stick_active, forward_flick,
                output ready);
endinterface

@@ sv/vsrd_cfg_if.sv @@
interface vsrd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vsrd_pkg::CFG_IDX_W-1:0]  index;
  logic [vsrd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/virtual_stick_radial_deadzone.sv @@
// Radial-deadzone virtual stick. Each word on in_ch is one touch sample; each produces
// exactly one word on out_ch, and a new sample is taken every clock while out_ch is not
// stalled. The pipeline's length is set by the chain of restoring dividers and
// square-root units, one result bit per pipeline stage: the
// normalized-magnitude divide (32 stages, in parallel with the 32-stage drag-length
// root), the magnitude root (16), the deadzone rescale divide (17) and the axis divide
// (16). A stalled output freezes the whole pipeline; the input side stays ready as
// long as the output register is empty or being taken. Configuration is accepted on
// every cycle and must only change while no sample is in flight.
module virtual_stick_radial_deadzone #(
  parameter int COORD_WIDTH = vsrd_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vsrd_in_if.sink     in_ch,
  vsrd_out_if.source  out_ch,
  vsrd_cfg_if.sink    cfg_ch
);
  import vsrd_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DSH = 31 - CW;
  localparam int RW  = CW + 4;
  localparam int R2W = 2 * CW + 8;

  typedef struct packed {
    logic [CW-1:0]      magx;
    logic [CW-1:0]      magy;
    logic               sgx;
    logic               sgy;
    logic [15:0]        elapsed;
    logic               started;
    logic [2*CW-1:0]    sqx;
    logic [2*CW-1:0]    sqy;
    logic [2*CW:0]      d2;
    logic               sat;
    logic               radnz;
    logic               d2nz;
    logic [R2W-1:0]     drem;
    logic [31:0]        q;
    logic [63:0]        sv;
    logic [33:0]        srem;
    logic [31:0]        sroot;
    logic [17:0]        mrem;
    logic [15:0]        mroot;
    logic               act;
    logic [16:0]        rrem;
    logic [16:0]        rn;
    logic [16:0]        rq;
    logic [47:0]        px;
    logic [47:0]        py;
    logic [62:0]        nx;
    logic [62:0]        ny;
    logic [31:0]        xrem;
    logic [31:0]        yrem;
    logic [15:0]        xn;
    logic [15:0]        yn;
    logic [15:0]        xq;
    logic [15:0]        yq;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               flick;
  } item_t;

  // Configuration registers and values derived from them
  logic [CW-1:0]    frame_width_r;
  logic [CW-1:0]    frame_height_r;
  logic [15:0]      act_frac_r;
  logic [15:0]      dead_zone_r;
  logic [CW-1:0]    side;
  logic [15:0]      frac;
  logic [CW+15:0]   rad_prod;
  logic [RW-1:0]    radius_r;
  logic [R2W-1:0]   r2_r;
  logic [16:0]      dz_den;

  logic [ST_OUT:0]  vld_r;
  item_t            pipe_r [0:ST_OUT];
  item_t            s0_nxt;
  logic             adv;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CW'(FRAME_RESET);
      frame_height_r <= CW'(FRAME_RESET);
      act_frac_r     <= FRACTION_RESET;
      dead_zone_r    <= DEAD_ZONE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FRAME_WIDTH:         frame_width_r  <= cfg_ch.data[CW-1:0];
        REG_FRAME_HEIGHT:        frame_height_r <= cfg_ch.data[CW-1:0];
        REG_ACTIVATION_FRACTION: act_frac_r     <= cfg_ch.data[15:0];
        REG_DEAD_ZONE:           dead_zone_r    <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    side     = (frame_width_r < frame_height_r) ? frame_width_r : frame_height_r;
    frac     = (act_frac_r < MIN_FRACTION) ? MIN_FRACTION : act_frac_r;
    rad_prod = side * frac;
    dz_den   = UNIT_Q16 - {1'b0, dead_zone_r};
  end

  always_ff @(posedge clk) begin
    radius_r <= rad_prod[CW+15:12];
    r2_r     <= radius_r * radius_r;
  end

  // Global advance: the pipeline moves unless the output word is held
  assign adv         = !vld_r[ST_OUT] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ST_OUT-1:0], in_ch.valid};
    end
  end

  always_comb begin
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    dx = $signed({1'b0, in_ch.current_x}) - $signed({1'b0, in_ch.anchor_x});
    dy = $signed({1'b0, in_ch.current_y}) - $signed({1'b0, in_ch.anchor_y});
    s0_nxt         = '0;
    s0_nxt.sgx     = dx[CW];
    s0_nxt.sgy     = dy[CW];
    s0_nxt.magx    = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    s0_nxt.magy    = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    s0_nxt.elapsed = in_ch.elapsed_ms;
    s0_nxt.started = in_ch.touch_started;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= s0_nxt;
    end
  end

  for (genvar s = 1; s <= ST_OUT; s++) begin : g_st
    item_t nxt;

    if (s == ST_SQ) begin : g_sq
      always_comb begin
        nxt     = pipe_r[s-1];
        nxt.sqx = pipe_r[s-1].magx * pipe_r[s-1].magx;
        nxt.sqy = pipe_r[s-1].magy * pipe_r[s-1].magy;
      end
    end else if (s == ST_SUM) begin : g_sum
      always_comb begin
        nxt    = pipe_r[s-1];
        nxt.d2 = {1'b0, pipe_r[s-1].sqx} + {1'b0, pipe_r[s-1].sqy};
      end
    end else if (s == ST_INIT) begin : g_init
      logic [R2W:0] d2q8;
      always_comb begin
        d2q8      = {pipe_r[s-1].d2, 8'd0};
        nxt       = pipe_r[s-1];
        nxt.sat   = d2q8 >= {1'b0, r2_r};
        nxt.radnz = radius_r != '0;
        nxt.d2nz  = pipe_r[s-1].d2 != '0;
        nxt.drem  = d2q8[R2W-1:0];
        nxt.q     = '0;
        nxt.sv    = 64'(pipe_r[s-1].d2) << (2 * DSH);
        nxt.srem  = '0;
        nxt.sroot = '0;
        nxt.mrem  = '0;
        nxt.mroot = '0;
      end
    end else if (s < ST_MSQ0) begin : g_div
      // One quotient bit of (d2 << 8)/R^2 and one root bit of the drag length
      logic [R2W:0] t;
      logic [35:0]  rt;
      logic [35:0]  tr;
      always_comb begin
        nxt = pipe_r[s-1];
        t   = {pipe_r[s-1].drem, 1'b0};
        if (t >= {1'b0, r2_r}) begin
          nxt.drem = R2W'(t - {1'b0, r2_r});
          nxt.q    = {pipe_r[s-1].q[30:0], 1'b1};
        end else begin
          nxt.drem = t[R2W-1:0];
          nxt.q    = {pipe_r[s-1].q[30:0], 1'b0};
        end
        rt     = {pipe_r[s-1].srem, pipe_r[s-1].sv[63:62]};
        tr     = {2'b00, pipe_r[s-1].sroot, 2'b01};
        nxt.sv = {pipe_r[s-1].sv[61:0], 2'b00};
        if (rt >= tr) begin
          nxt.srem  = 34'(rt - tr);
          nxt.sroot = {pipe_r[s-1].sroot[30:0], 1'b1};
        end else begin
          nxt.srem  = rt[33:0];
          nxt.sroot = {pipe_r[s-1].sroot[30:0], 1'b0};
        end
      end
    end else if (s < ST_MAG) begin : g_msq
      logic [19:0] rt;
      logic [19:0] tr;
      always_comb begin
        nxt   = pipe_r[s-1];
        rt    = {pipe_r[s-1].mrem, pipe_r[s-1].q[31:30]};
        tr    = {2'b00, pipe_r[s-1].mroot, 2'b01};
        nxt.q = {pipe_r[s-1].q[29:0], 2'b00};
        if (rt >= tr) begin
          nxt.mrem  = 18'(rt - tr);
          nxt.mroot = {pipe_r[s-1].mroot[14:0], 1'b1};
        end else begin
          nxt.mrem  = rt[17:0];
          nxt.mroot = {pipe_r[s-1].mroot[14:0], 1'b0};
        end
      end
    end else if (s == ST_MAG) begin : g_mag
      logic [16:0] m;
      logic [16:0] mdz;
      always_comb begin
        nxt     = pipe_r[s-1];
        m       = pipe_r[s-1].sat ? UNIT_Q16 : {1'b0, pipe_r[s-1].mroot};
        mdz     = m - {1'b0, dead_zone_r};
        nxt.act = pipe_r[s-1].radnz && pipe_r[s-1].d2nz && (m != '0) &&
                  (m >= {1'b0, dead_zone_r});
        nxt.rrem = {1'b0, mdz[16:1]};
        nxt.rn   = {mdz[0], 16'd0};
        nxt.rq   = '0;
      end
    end else if (s < ST_PROD) begin : g_rdiv
      logic [17:0] t;
      always_comb begin
        nxt    = pipe_r[s-1];
        t      = {pipe_r[s-1].rrem, pipe_r[s-1].rn[16]};
        nxt.rn = {pipe_r[s-1].rn[15:0], 1'b0};
        if (t >= {1'b0, dz_den}) begin
          nxt.rrem = 17'(t - {1'b0, dz_den});
          nxt.rq   = {pipe_r[s-1].rq[15:0], 1'b1};
        end else begin
          nxt.rrem = t[16:0];
          nxt.rq   = {pipe_r[s-1].rq[15:0], 1'b0};
        end
      end
    end else if (s == ST_PROD) begin : g_prod
      logic [16:0] r;
      logic [30:0] mx;
      logic [30:0] my;
      always_comb begin
        nxt    = pipe_r[s-1];
        r      = (pipe_r[s-1].rq > UNIT_Q16) ? UNIT_Q16 : pipe_r[s-1].rq;
        mx     = 31'(pipe_r[s-1].magx) << DSH;
        my     = 31'(pipe_r[s-1].magy) << DSH;
        nxt.px = mx * r;
        nxt.py = my * r;
      end
    end else if (s == ST_NEG) begin : g_neg
      // times 32767 as a shift and subtract
      always_comb begin
        nxt    = pipe_r[s-1];
        nxt.nx = (63'(pipe_r[s-1].px) << 15) - 63'(pipe_r[s-1].px);
        nxt.ny = (63'(pipe_r[s-1].py) << 15) - 63'(pipe_r[s-1].py);
      end
    end else if (s == ST_ASUM) begin : g_asum
      // add half the divisor for rounding, drop the 2^16 of the divisor
      logic [63:0] hx;
      logic [63:0] hy;
      logic [63:0] half;
      always_comb begin
        nxt      = pipe_r[s-1];
        half     = 64'(pipe_r[s-1].sroot) << 15;
        hx       = 64'(pipe_r[s-1].nx) + half;
        hy       = 64'(pipe_r[s-1].ny) + half;
        nxt.xrem = hx[63:32];
        nxt.xn   = hx[31:16];
        nxt.yrem = hy[63:32];
        nxt.yn   = hy[31:16];
        nxt.xq   = '0;
        nxt.yq   = '0;
      end
    end else if (s < ST_OUT) begin : g_adiv
      logic [32:0] tx;
      logic [32:0] ty;
      logic [32:0] dv;
      always_comb begin
        nxt    = pipe_r[s-1];
        dv     = {1'b0, pipe_r[s-1].sroot};
        tx     = {pipe_r[s-1].xrem, pipe_r[s-1].xn[15]};
        ty     = {pipe_r[s-1].yrem, pipe_r[s-1].yn[15]};
        nxt.xn = {pipe_r[s-1].xn[14:0], 1'b0};
        nxt.yn = {pipe_r[s-1].yn[14:0], 1'b0};
        if (tx >= dv) begin
          nxt.xrem = 32'(tx - dv);
          nxt.xq   = {pipe_r[s-1].xq[14:0], 1'b1};
        end else begin
          nxt.xrem = tx[31:0];
          nxt.xq   = {pipe_r[s-1].xq[14:0], 1'b0};
        end
        if (ty >= dv) begin
          nxt.yrem = 32'(ty - dv);
          nxt.yq   = {pipe_r[s-1].yq[14:0], 1'b1};
        end else begin
          nxt.yrem = ty[31:0];
          nxt.yq   = {pipe_r[s-1].yq[14:0], 1'b0};
        end
      end
    end else begin : g_out
      logic [15:0]        xc;
      logic [15:0]        yc;
      logic signed [15:0] sxv;
      logic signed [15:0] syv;
      always_comb begin
        nxt = pipe_r[s-1];
        xc  = (pipe_r[s-1].xq > AXIS_MAX) ? AXIS_MAX : pipe_r[s-1].xq;
        yc  = (pipe_r[s-1].yq > AXIS_MAX) ? AXIS_MAX : pipe_r[s-1].yq;
        sxv = '0;
        syv = '0;
        if (pipe_r[s-1].act) begin
          sxv = pipe_r[s-1].sgx ? -$signed(xc) : $signed(xc);
          syv = pipe_r[s-1].sgy ? -$signed(yc) : $signed(yc);
        end
        nxt.sx    = sxv;
        nxt.sy    = syv;
        nxt.flick = pipe_r[s-1].started && (pipe_r[s-1].elapsed <= FLICK_MS) &&
                    (syv <= -FLICK_AXIS) && (sxv <= FLICK_AXIS) &&
                    (sxv >= -FLICK_AXIS);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[s] <= nxt;
      end
    end
  end

  assign out_ch.valid         = vld_r[ST_OUT];
  assign out_ch.stick_x       = pipe_r[ST_OUT].sx;
  assign out_ch.stick_y       = pipe_r[ST_OUT].sy;
  assign out_ch.stick_active  = pipe_r[ST_OUT].act;
  assign out_ch.forward_flick = pipe_r[ST_OUT].flick;

endmodule

@@ sv/vsrd_chk.sv @@
module vsrd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] stick_x,
  input logic signed [15:0] stick_y,
  input logic               stick_active,
  input logic               forward_flick
);
  import vsrd_pkg::*;

  // a held word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(stick_x) && $stable(stick_y) &&
    $stable(stick_active) && $stable(forward_flick))
    else $error("output word changed while stalled");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is frozen");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !stick_active |-> stick_x == 16'sd0 && stick_y == 16'sd0)
    else $error("inactive stick with nonzero axes");

  a_flick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && forward_flick |-> stick_active && stick_y <= -FLICK_AXIS &&
    stick_x <= FLICK_AXIS && stick_x >= -FLICK_AXIS)
    else $error("flick without matching deflection");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> stick_x != -16'sd32768 && stick_y != -16'sd32768)
    else $error("axis out of range");

endmodule

bind virtual_stick_radial_deadzone vsrd_chk u_vsrd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .stick_x       (out_ch.stick_x),
  .stick_y       (out_ch.stick_y),
  .stick_active  (out_ch.stick_active),
  .forward_flick (out_ch.forward_flick)
);

@@ test/virtual_stick_radial_deadzone_tb.sv @@
module virtual_stick_radial_deadzone_tb;
  import vsrd_pkg::*;

  localparam int CW = 16;
  localparam int DSH = 31 - CW;
  localparam int LATENCY = ST_OUT + 1;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [15:0]   ms;
    logic          started;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               active;
    logic               flick;
  } stick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vsrd_in_if #(.CW(CW)) in_ch ();
  vsrd_out_if out_ch ();
  vsrd_cfg_if cfg_ch ();

  virtual_stick_radial_deadzone #(.COORD_WIDTH(CW)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] frame_w, frame_h, act_frac, dz;
  stick_t      expected_q[$];
  int          errors = 0;
  longint      cycles = 0;
  int          burst_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.anchor_x = '0;
    in_ch.anchor_y = '0;
    in_ch.current_x = '0;
    in_ch.current_y = '0;
    in_ch.elapsed_ms = '0;
    in_ch.touch_started = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] scale_axis(longint delta, logic [63:0] drag_len,
                                                     logic [63:0] r);
    logic [63:0] mag, num, den, q;
    mag = (delta < 0) ? -delta : delta;
    num = (mag << DSH) * r * 64'd32767;
    den = drag_len * 64'd65536;
    q = (num + den / 2) / den;
    if (q > 32767) q = 32767;
    return (delta < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  function automatic stick_t predict_stick(sample_t s);
    stick_t o;
    longint dx, dy;
    logic [63:0] side, frac, radius, d2, d2q8, r2, m, r, drag_len, rem, q;
    dx = longint'(s.cx) - longint'(s.ax);
    dy = longint'(s.cy) - longint'(s.ay);
    side = (frame_w < frame_h) ? frame_w : frame_h;
    frac = (act_frac < MIN_FRACTION) ? 64'(MIN_FRACTION) : act_frac;
    radius = (side * frac) >> 12;
    d2 = dx * dx + dy * dy;
    o = '0;
    if (radius != 0 && d2 != 0) begin
      d2q8 = d2 << 8;
      r2 = radius * radius;
      if (d2q8 >= r2) begin
        m = 65536;
      end else begin
        rem = d2q8;
        q = 0;
        for (int i = 0; i < 32; i++) begin
          rem <<= 1;
          q <<= 1;
          if (rem >= r2) begin
            rem -= r2;
            q |= 1;
          end
        end
        m = root64(q);
      end
      if (m != 0 && m >= dz) begin
        r = ((m - dz) * 65536) / (65536 - dz);
        if (r > 65536) r = 65536;
        drag_len = root64(d2 << (2 * DSH));
        o.active = 1'b1;
        o.sx = scale_axis(dx, drag_len, r);
        o.sy = scale_axis(dy, drag_len, r);
      end
    end
    o.flick = s.started && s.ms <= FLICK_MS && o.sy <= -FLICK_AXIS &&
              o.sx <= FLICK_AXIS && o.sx >= -FLICK_AXIS;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // receiver stall pattern: long open stretches, then spells of random stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 3000 < 1200) out_ch.ready <= 1'b1;
    else if (cycles % 3000 < 2000) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    stick_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word stick_x", out_ch.stick_x, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_ch.stick_x !== w.sx) report_mismatch("stick_x", out_ch.stick_x, w.sx);
        if (out_ch.stick_y !== w.sy) report_mismatch("stick_y", out_ch.stick_y, w.sy);
        if (out_ch.stick_active !== w.active)
          report_mismatch("stick_active", out_ch.stick_active, w.active);
        if (out_ch.forward_flick !== w.flick)
          report_mismatch("forward_flick", out_ch.forward_flick, w.flick);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // valid stays high between writes; the caller drops it after the last one
  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value[31:0];
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_FRAME_WIDTH: frame_w = value & 64'hFFFF;
      REG_FRAME_HEIGHT: frame_h = value & 64'hFFFF;
      REG_ACTIVATION_FRACTION: act_frac = value & 64'hFFFF;
      REG_DEAD_ZONE: dz = value & 64'hFFFF;
      default: ;
    endcase
  endtask

  // drop valid if a burst is still open
  task automatic end_burst();
    if (burst_left != 0) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic drain();
    end_burst();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_config(logic [63:0] w, logic [63:0] h, logic [63:0] f,
                            logic [63:0] d);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_ACTIVATION_FRACTION, f);
    write_reg(REG_DEAD_ZONE, d);
    cfg_ch.valid <= 1'b0;
  endtask

  // send one word, with bursty gaps; valid stays high across back-to-back words
  task automatic send_sample(sample_t s);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.anchor_x <= s.ax;
    in_ch.anchor_y <= s.ay;
    in_ch.current_x <= s.cx;
    in_ch.current_y <= s.cy;
    in_ch.elapsed_ms <= s.ms;
    in_ch.touch_started <= s.started;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_stick(s));
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  function automatic sample_t drag(int ax, int ay, int ddx, int ddy, int ms, bit st);
    sample_t s;
    s.ax = CW'(ax);
    s.ay = CW'(ay);
    s.cx = CW'(ax + ddx);
    s.cy = CW'(ay + ddy);
    s.ms = 16'(ms);
    s.started = st;
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int rad, ax, ay;
    s.ax = CW'($urandom);
    s.ay = CW'($urandom);
    s.cx = CW'($urandom);
    s.cy = CW'($urandom);
    s.started = 1'($urandom);
    s.ms = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 700)) : 16'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      // drag near the stick radius, up-biased so flicks show up
      rad = int'(((frame_w < frame_h ? frame_w : frame_h) * 4) / 16) + 2;
      ax = int'($urandom_range(2 * rad + 40, 65535 - 2 * rad - 40));
      ay = int'($urandom_range(2 * rad + 40, 65535 - 2 * rad - 40));
      s = drag(ax, ay, int'($urandom_range(0, 3 * rad)) - 3 * rad / 2,
               int'($urandom_range(0, 3 * rad)) - 2 * rad, s.ms, s.started);
    end
    return s;
  endfunction

  task automatic test_directed();
    send_sample(drag(4000, 4000, 0, 0, 0, 1));
    send_sample(drag(4000, 4000, 0, -500, 100, 1));
    send_sample(drag(4000, 4000, 0, -500, 341, 1));
    send_sample(drag(4000, 4000, 0, -500, 100, 0));
    send_sample(drag(4000, 4000, 300, -300, 340, 1));
    send_sample(drag(4000, 4000, 400, 0, 0, 1));
    send_sample(drag(4000, 4000, -30, 10, 0, 1));
    send_sample(drag(4000, 4000, 5, 5, 0, 1));
    send_sample(drag(4000, 4000, 0, 3, 0, 1));
    send_sample(drag(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
    send_sample(drag(16'hFFFF, 16'hFFFF, -65535, -65535, 0, 1));
    send_sample(drag(16'hFFFF, 0, -65535, 0, 0, 1));
    send_sample(drag(0, 16'hFFFF, 100, -200, 200, 1));
    send_sample(drag(16'h5555, 16'hAAAA, 200, 100, 16'hAAAA, 0));
  endtask

  task automatic test_frame_extremes();
    set_config(0, 2048, 15729, 6554);
    send_sample(drag(4000, 4000, 0, -500, 0, 1));
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_sample(drag(0, 16'hFFFF, 16'hFFFF, -65535, 0, 1));
    send_sample(drag(30000, 30000, 100, -9000, 0, 1));
    send_sample(drag(30000, 30000, 0, 1, 0, 1));
    set_config(1, 16'hFFFF, 0, 62259);
    send_sample(drag(100, 100, 1, 1, 0, 1));
    send_sample(drag(100, 100, 0, -1, 0, 1));
    set_config(3000, 800, 40000, 62259);
    send_sample(drag(5000, 5000, 0, -700, 10, 1));
    send_sample(drag(5000, 5000, 0, -180, 10, 1));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_sample(random_sample());
  endtask

  task automatic test_idle_pause();
    end_burst();
    while (expected_q.size() != 0) @(posedge clk);
    test_random(20);
  endtask

  initial begin
    frame_w = 2048;
    frame_h = 2048;
    act_frac = 15729;
    dz = 6554;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_frame_extremes();
    set_config(2048, 2048, 15729, 6554);
    test_random(200);
    test_idle_pause();
    set_config(1024, 3000, 20000, 0);
    test_random(150);
    set_config(16'hFFFF, 4000, 16'hFFFF, 30000);
    test_random(150);
    set_config($urandom, $urandom, $urandom, $urandom_range(0, 62259));
    test_random(150);
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
